/* design/bffd_pkg.sv */
package bffd_pkg;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POW   = 7'b0000010,
        S_WA    = 7'b0000100,
        S_WB    = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    localparam logic [1:0] CFG_DEG_X = 2'd0;
    localparam logic [1:0] CFG_DEG_Y = 2'd1;
    localparam logic [1:0] CFG_DEG_Z = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DEFORM = 1'b1;

    localparam int DEF_MAX_DEGREE      = 7;
    localparam int DEF_COORD_FRAC_BITS = 16;

    localparam logic [2:0] DEG_RESET = 3'd3;

    // binomial coefficients C(n, m), row n, column m; rows 13 to 15 are zero
    localparam logic [9:0] PASCAL [16][16] = '{
        '{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd2, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd3, 10'd3, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd4, 10'd6, 10'd4, 10'd1, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd5, 10'd10, 10'd10, 10'd5, 10'd1, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd6, 10'd15, 10'd20, 10'd15, 10'd6, 10'd1, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd7, 10'd21, 10'd35, 10'd35, 10'd21, 10'd7, 10'd1,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd8, 10'd28, 10'd56, 10'd70, 10'd56, 10'd28, 10'd8,
          10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd9, 10'd36, 10'd84, 10'd126, 10'd126, 10'd84, 10'd36,
          10'd9, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210, 10'd120,
          10'd45, 10'd10, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462, 10'd330,
          10'd165, 10'd55, 10'd11, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924, 10'd792,
          10'd495, 10'd220, 10'd66, 10'd12, 10'd1, 10'd0, 10'd0, 10'd0},
        '{16{10'd0}},
        '{16{10'd0}},
        '{16{10'd0}}
    };

endpackage

/* design/bernstein_ffd_deform_unit.sv */
// Trivariate Bernstein free-form deformation unit.
// Input channel (i_in_valid / o_in_stall): op 0 loads one control point
// (lattice_i/j/k, point_x/y/z in Q16.16) into the lattice memory and returns
// nothing; op 1 deforms a vertex (coord_u/v/w) and returns one transaction
// on the output channel (o_out_valid / i_out_stall).
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0..2
// writes degree_x/y/z; write it only while the unit is idle.
// Course of a deform: weight setup for the three axes, then one lattice
// read per cycle, (dx+1)(dy+1)(dz+1) reads, then pipeline drain and
// output. The single read port of the lattice memory limits the reads to
// one per cycle. One item is worked on at a time; o_in_stall is high while
// a deform is in progress.
// A finished result waits in the output register while i_out_stall is high;
// the next item is accepted meanwhile, and the next result holds back until
// the register frees up.
// Reset (synchronous, active low) sets all degrees to 3 and empties the
// pipeline; the lattice memory is not cleared and must be loaded first.
module bernstein_ffd_deform_unit
    import bffd_pkg::*;
#(
    parameter int MAX_DEGREE      = DEF_MAX_DEGREE,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [2:0]         i_lattice_i,
    input  logic [2:0]         i_lattice_j,
    input  logic [2:0]         i_lattice_k,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic [16:0]        i_coord_u,
    input  logic [16:0]        i_coord_v,
    input  logic [16:0]        i_coord_w,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_deformed_x,
    output logic signed [31:0] o_deformed_y,
    output logic signed [31:0] o_deformed_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [2:0]         i_cfg_data
);

    localparam int S     = MAX_DEGREE + 1;
    localparam int IW    = $clog2(S);
    localparam int ADW   = 3 * IW;
    localparam int DEPTH = 1 << ADW;
    localparam int F     = COORD_FRAC_BITS;
    localparam int WW    = F + 2;
    localparam int RW    = 35;
    localparam int CW    = (F + 1 > 17) ? F + 1 : 17;

    localparam logic [F:0]        ONE    = {1'b1, {F{1'b0}}};
    localparam logic [2*F+1:0]    HALF_P = {{(F+2){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic [2*F+11:0]   HALF_C = {{(F+12){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [63:0] HALF64 = 64'sd1 <<< (F - 1);

    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] a);
        f_rnd = (a + HALF64) >>> F;
    endfunction

    function automatic logic [IW-1:0] f_clamp(input logic [2:0] d);
        if (int'(d) > MAX_DEGREE) begin
            f_clamp = IW'(MAX_DEGREE);
        end else begin
            f_clamp = IW'(d);
        end
    endfunction

    t_state r_state, n_state;

    logic [2:0] r_deg_x, r_deg_y, r_deg_z;
    logic [IW-1:0] dx, dy, dz, cur_d, next_d;

    logic [16:0] r_cu, r_cv, r_cw;
    logic [1:0]  r_axis;
    logic [IW-1:0] r_m;
    logic [F:0] r_tp [S];
    logic [F:0] r_sp [S];
    logic [2*F+1:0] r_wprod;
    logic [WW-1:0] r_wu [S];
    logic [WW-1:0] r_wv [S];
    logic [WW-1:0] r_ww [S];

    logic [16:0]    coord_sel;
    logic [CW-1:0]  coord_ext;
    logic [F:0]     t_val, s_val, tp_prev, sp_prev, tp_m, sp_dm;
    logic [IW-1:0]  m_prev, dm;
    logic [2*F+1:0] pow_t, pow_s;
    logic [2*F+11:0] wgt_full;

    logic [95:0] mem_lat [DEPTH];
    logic [95:0] r_rd;

    logic [IW-1:0] r_i, r_j, r_k;
    logic last_k, last_j, last_i, issue_end;

    logic in_acc, load_ok, out_free;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic r_lk1, r_lj1, r_li1, r_lk2, r_lj2, r_li2;
    logic r_lj3, r_li3, r_lj4, r_li4, r_lj5, r_li5, r_li6, r_li7, r_li8;
    logic [IW-1:0] r_j1, r_i1, r_j2, r_i2, r_j3, r_i3, r_j4, r_i4, r_i5, r_i6, r_i7;
    logic [WW-1:0] r_wk1;

    logic signed [63:0]   r_p   [3];
    logic signed [63:0]   r_sk  [3];
    logic signed [63:0]   r_skc [3];
    logic signed [RW-1:0] r_skr [3];
    logic signed [63:0]   r_jp  [3];
    logic signed [63:0]   r_sj  [3];
    logic signed [63:0]   r_sjc [3];
    logic signed [RW-1:0] r_sjr [3];
    logic signed [63:0]   r_ip  [3];
    logic signed [63:0]   r_acc [3];
    logic signed [63:0]   r_accf [3];
    logic signed [31:0]   r_res [3];
    logic signed [63:0]   fin [3];
    logic signed [31:0]   sat [3];
    logic r_done, r_out_valid;

    assign dx = f_clamp(r_deg_x);
    assign dy = f_clamp(r_deg_y);
    assign dz = f_clamp(r_deg_z);

    always_comb begin
        case (r_axis)
            2'd0: begin
                cur_d = dx;
                next_d = dy;
                coord_sel = r_cu;
            end
            2'd1: begin
                cur_d = dy;
                next_d = dz;
                coord_sel = r_cv;
            end
            default: begin
                cur_d = dz;
                next_d = dz;
                coord_sel = r_cw;
            end
        endcase
    end

    always_comb begin
        coord_ext = CW'(coord_sel);
        t_val = (coord_ext > CW'(ONE)) ? ONE : (F+1)'(coord_ext);
        s_val = ONE - t_val;
        m_prev = r_m - IW'(1);
        dm = cur_d - r_m;
        tp_prev = (m_prev == '0) ? ONE : r_tp[m_prev];
        sp_prev = (m_prev == '0) ? ONE : r_sp[m_prev];
        tp_m = (r_m == '0) ? ONE : r_tp[r_m];
        sp_dm = (dm == '0) ? ONE : r_sp[dm];
        pow_t = (2*F+2)'(tp_prev) * (2*F+2)'(t_val) + HALF_P;
        pow_s = (2*F+2)'(sp_prev) * (2*F+2)'(s_val) + HALF_P;
        wgt_full = (2*F+12)'(PASCAL[4'(cur_d)][4'(r_m)]) * (2*F+12)'(r_wprod) + HALF_C;
    end

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign load_ok  = (int'(i_lattice_i) <= MAX_DEGREE) && (int'(i_lattice_j) <= MAX_DEGREE)
                      && (int'(i_lattice_k) <= MAX_DEGREE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign last_k    = (r_k == dz);
    assign last_j    = (r_j == dy);
    assign last_i    = (r_i == dx);
    assign issue_end = last_k && last_j && last_i;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_op == OP_DEFORM) begin
                    n_state = (dx == '0) ? S_WA : S_POW;
                end
            end
            S_POW: begin
                if (r_m == cur_d) begin
                    n_state = S_WA;
                end
            end
            S_WA: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (r_m != cur_d) begin
                    n_state = S_WA;
                end else if (r_axis == 2'd2) begin
                    n_state = S_ACC;
                end else begin
                    n_state = (next_d == '0) ? S_WA : S_POW;
                end
            end
            S_ACC: begin
                if (issue_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_deg_x <= DEG_RESET;
            r_deg_y <= DEG_RESET;
            r_deg_z <= DEG_RESET;
            r_axis <= '0;
            r_m <= '0;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8} <= '0;
            r_done <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_sk[c] <= '0;
                r_sj[c] <= '0;
                r_acc[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DEG_X: r_deg_x <= i_cfg_data;
                    CFG_DEG_Y: r_deg_y <= i_cfg_data;
                    CFG_DEG_Z: r_deg_z <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_op == OP_DEFORM) begin
                        r_axis <= '0;
                        r_m <= (dx == '0) ? '0 : IW'(1);
                        r_i <= '0;
                        r_j <= '0;
                        r_k <= '0;
                    end
                end
                S_POW: begin
                    r_m <= (r_m == cur_d) ? '0 : r_m + IW'(1);
                end
                S_WB: begin
                    if (r_m != cur_d) begin
                        r_m <= r_m + IW'(1);
                    end else if (r_axis != 2'd2) begin
                        r_axis <= r_axis + 2'd1;
                        r_m <= (next_d == '0) ? '0 : IW'(1);
                    end
                end
                S_ACC: begin
                    if (!last_k) begin
                        r_k <= r_k + IW'(1);
                    end else begin
                        r_k <= '0;
                        if (!last_j) begin
                            r_j <= r_j + IW'(1);
                        end else begin
                            r_j <= '0;
                            r_i <= r_i + IW'(1);
                        end
                    end
                end
                default: ;
            endcase

            r_v1 <= (r_state == S_ACC);
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_lk2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5 && r_lj5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;

            for (int c = 0; c < 3; c++) begin
                if (r_v2) begin
                    if (r_lk2) begin
                        r_sk[c] <= '0;
                    end else begin
                        r_sk[c] <= r_sk[c] + r_p[c];
                    end
                end
                if (r_v5) begin
                    if (r_lj5) begin
                        r_sj[c] <= '0;
                    end else begin
                        r_sj[c] <= r_sj[c] + r_jp[c];
                    end
                end
                if (r_v8) begin
                    if (r_li8) begin
                        r_acc[c] <= '0;
                    end else begin
                        r_acc[c] <= r_acc[c] + r_ip[c];
                    end
                end
            end

            if (r_v8 && r_li8) begin
                r_done <= 1'b1;
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_done <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // lattice memory
    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == OP_LOAD && load_ok) begin
            mem_lat[{IW'(i_lattice_i), IW'(i_lattice_j), IW'(i_lattice_k)}]
                <= {i_point_x, i_point_y, i_point_z};
        end
        r_rd <= mem_lat[{r_i, r_j, r_k}];
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fin[c] = f_rnd(r_accf[c]);
            if (fin[c] > 64'sd2147483647) begin
                sat[c] = 32'sh7FFFFFFF;
            end else if (fin[c] < -64'sd2147483648) begin
                sat[c] = 32'sh80000000;
            end else begin
                sat[c] = 32'(fin[c]);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == OP_DEFORM) begin
            r_cu <= i_coord_u;
            r_cv <= i_coord_v;
            r_cw <= i_coord_w;
        end
        if (r_state == S_POW) begin
            r_tp[r_m] <= pow_t[2*F:F];
            r_sp[r_m] <= pow_s[2*F:F];
        end
        if (r_state == S_WA) begin
            r_wprod <= (2*F+2)'(tp_m) * (2*F+2)'(sp_dm);
        end
        if (r_state == S_WB) begin
            case (r_axis)
                2'd0: r_wu[r_m] <= wgt_full[2*F+1:F];
                2'd1: r_wv[r_m] <= wgt_full[2*F+1:F];
                default: r_ww[r_m] <= wgt_full[2*F+1:F];
            endcase
        end

        r_wk1 <= r_ww[r_k];
        r_lk1 <= last_k;
        r_lj1 <= last_j;
        r_li1 <= last_i;
        r_j1 <= r_j;
        r_i1 <= r_i;

        r_lk2 <= r_lk1;
        r_lj2 <= r_lj1;
        r_li2 <= r_li1;
        r_j2 <= r_j1;
        r_i2 <= r_i1;
        r_p[0] <= 64'($signed({1'b0, r_wk1}) * $signed(r_rd[95:64]));
        r_p[1] <= 64'($signed({1'b0, r_wk1}) * $signed(r_rd[63:32]));
        r_p[2] <= 64'($signed({1'b0, r_wk1}) * $signed(r_rd[31:0]));

        r_lj3 <= r_lj2;
        r_li3 <= r_li2;
        r_j3 <= r_j2;
        r_i3 <= r_i2;
        r_lj4 <= r_lj3;
        r_li4 <= r_li3;
        r_j4 <= r_j3;
        r_i4 <= r_i3;
        r_lj5 <= r_lj4;
        r_li5 <= r_li4;
        r_i5 <= r_i4;
        r_li6 <= r_li5;
        r_i6 <= r_i5;
        r_li7 <= r_li6;
        r_i7 <= r_i6;
        r_li8 <= r_li7;

        for (int c = 0; c < 3; c++) begin
            if (r_v2 && r_lk2) begin
                r_skc[c] <= r_sk[c] + r_p[c];
            end
            r_skr[c] <= RW'(f_rnd(r_skc[c]));
            r_jp[c] <= 64'($signed({1'b0, r_wv[r_j4]}) * r_skr[c]);
            if (r_v5 && r_lj5) begin
                r_sjc[c] <= r_sj[c] + r_jp[c];
            end
            r_sjr[c] <= RW'(f_rnd(r_sjc[c]));
            r_ip[c] <= 64'($signed({1'b0, r_wu[r_i7]}) * r_sjr[c]);
            if (r_v8 && r_li8) begin
                r_accf[c] <= r_acc[c] + r_ip[c];
            end
            if (r_state == S_EMIT && out_free) begin
                r_res[c] <= sat[c];
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_deformed_x = r_res[0];
    assign o_deformed_y = r_res[1];
    assign o_deformed_z = r_res[2];

    a_done_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_DRAIN || r_state == S_EMIT))
        else $error("finished sum outside drain or emit");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_v6 || r_v7 || r_v8))
        else $error("pipeline busy while idle");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (r_acc[0] == 0 && r_acc[1] == 0 && r_acc[2] == 0
             && r_sk[0] == 0 && r_sj[0] == 0))
        else $error("accumulators not cleared after transaction");

endmodule
